// ===== rtl/core/glc_pkg.sv =====
`timescale 1ns / 1ps

package glc_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_FONT_TAG_A = 2'd0;
   localparam logic [1:0] CSR_FONT_TAG_B = 2'd1;

   // lookup sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   // one cache entry as held in the store
   typedef struct packed {
      logic [15:0] char_code;
      logic [7:0]  font_a;
      logic [7:0]  font_b;
      logic [31:0] stamp;
   } entry_type;

endpackage

// ===== rtl/core/glc_entry_store.sv =====
`timescale 1ns / 1ps

module glc_entry_store
   import glc_pkg::*;
#(
   parameter int ENTRIES = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  entry_type                  wr_entry,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output entry_type                  rd_entry
);

   entry_type          mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   entry_type          rd_data_ff;
   logic               rd_valid_ff;

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // per-entry valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // an entry never written reads as all zero
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/core/glyph_cache_lru_lookup.sv =====
`timescale 1ns / 1ps
// a hit at entry k ends the entry scan early, a miss scans every entry;
// busy is high from accept until the strobe cycle
// a new request is taken only while busy is low, since each lookup scans entries
// through the single memory read port and the one shared tag/stamp compare
// reset: synchronous, invalidates all entries and clears the use counter; font tags go
// to 0xFE and 0xF7; results cannot be stalled by the receiver

module glyph_cache_lru_lookup
   import glc_pkg::*;
#(
   parameter int ENTRIES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [15:0]       req_char_code,
   output logic              rsp_valid,
   output logic              rsp_hit,
   output logic [6:0]        rsp_slot,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic signed [7:0] csr_wdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type         state_ff, state_in;
   logic signed [7:0] font_tag_a_ff, font_tag_b_ff;
   logic [15:0]       code_ff;
   logic [31:0]       use_counter_ff, use_counter_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              cmp_en_ff;
   logic              have_best_ff, have_best_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [31:0]       best_stamp_ff, best_stamp_in;
   logic [IDX_W-1:0]  tgt_ff, tgt_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff;
   logic [6:0]        rsp_slot_ff;

   entry_type rd_entry;
   entry_type wr_entry;
   logic      wr_en;
   logic      accept;
   logic      cmp_active;
   logic      tag_match;
   logic      cand_better;

   glc_entry_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (tgt_ff),
      .wr_entry (wr_entry),
      .rd_addr  (addr_ff),
      .rd_entry (rd_entry)
   );

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         font_tag_a_ff <= -8'sd2;
         font_tag_b_ff <= -8'sd9;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FONT_TAG_A: font_tag_a_ff <= csr_wdata;
            CSR_FONT_TAG_B: font_tag_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared compare unit: tag equality and stamp minimum
   assign cmp_active  = cmp_en_ff && (state_ff == ST_SCAN || state_ff == ST_DRAIN);
   assign tag_match   = (rd_entry.char_code == code_ff)
                     && (rd_entry.font_a == font_tag_a_ff)
                     && (rd_entry.font_b == font_tag_b_ff);
   assign cand_better = !have_best_ff || (rd_entry.stamp < best_stamp_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_active && tag_match) begin
               state_in = ST_RESP;
            end else if (addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and scan datapath
   always_comb begin
      addr_in        = addr_ff;
      have_best_in   = have_best_ff;
      best_idx_in    = best_idx_ff;
      best_stamp_in  = best_stamp_ff;
      tgt_in         = tgt_ff;
      hit_in         = hit_ff;
      use_counter_in = use_counter_ff;
      rsp_valid_in   = 1'b0;
      wr_en          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            addr_in      = '0;
            have_best_in = 1'b0;
            hit_in       = 1'b0;
         end
         ST_SCAN, ST_DRAIN: begin
            if (state_ff == ST_SCAN && addr_ff != LAST_IDX) begin
               addr_in = addr_ff + 1'b1;
            end
            if (cmp_active) begin
               if (tag_match) begin
                  hit_in = 1'b1;
                  tgt_in = cmp_idx_ff;
               end else begin
                  if (cand_better) begin
                     have_best_in  = 1'b1;
                     best_idx_in   = cmp_idx_ff;
                     best_stamp_in = rd_entry.stamp;
                  end
                  // last entry compared without a hit: pick the victim
                  if (state_ff == ST_DRAIN) begin
                     tgt_in = cand_better ? cmp_idx_ff : best_idx_ff;
                  end
               end
            end
         end
         ST_RESP: begin
            wr_en          = 1'b1;
            use_counter_in = use_counter_ff + 32'd1;
            rsp_valid_in   = 1'b1;
         end
         default: ;
      endcase
   end

   // write back tags and the new stamp for a hit or a replacement
   always_comb begin
      wr_entry.char_code = code_ff;
      wr_entry.font_a    = font_tag_a_ff;
      wr_entry.font_b    = font_tag_b_ff;
      wr_entry.stamp     = use_counter_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         use_counter_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         cmp_en_ff      <= 1'b0;
         have_best_ff   <= 1'b0;
         hit_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         use_counter_ff <= use_counter_in;
         rsp_valid_ff   <= rsp_valid_in;
         cmp_en_ff      <= (state_ff == ST_SCAN);
         have_best_ff   <= have_best_in;
         hit_ff         <= hit_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      cmp_idx_ff    <= addr_ff;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      tgt_ff        <= tgt_in;
      if (accept) begin
         code_ff <= req_char_code;
      end
      if (state_ff == ST_RESP) begin
         rsp_hit_ff  <= hit_ff;
         rsp_slot_ff <= 7'(tgt_ff);
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_slot  = rsp_slot_ff;

endmodule
